@@ design/tli_pkg.sv @@
// ----------------------------------------------------------------------------
// tli_pkg
// Shared constants, codes, types and value conversions for the table
// linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;

  localparam int FIELD_W = 32;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;
  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int ACC_W   = 2 * VALUE_WIDTH + 2;
  localparam int STEP_W  = $clog2(VALUE_WIDTH);
  localparam int ENTRY_W = 2 * VALUE_WIDTH;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic REG_DESCENDING  = 1'b0;
  localparam logic REG_ENTRY_COUNT = 1'b1;

  localparam logic [1:0] CLAMP_NONE  = 2'd0;
  localparam logic [1:0] CLAMP_FIRST = 2'd1;
  localparam logic [1:0] CLAMP_LAST  = 2'd2;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [ACC_W-1:0]       acc_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEARCH,
    S_WA,
    S_WB,
    S_DIST,
    S_MUL_A,
    S_MUL_B,
    S_ABS,
    S_DIV,
    S_FIX,
    S_PUT
  } state_t;

  // port field to internal value width, sign extended or wrapped
  function automatic value_t to_value(input logic [FIELD_W-1:0] v);
    return VALUE_WIDTH'($signed(v));
  endfunction

  // internal value to port field, low bits of the sign-extended value
  function automatic logic [FIELD_W-1:0] to_field(input value_t v);
    return FIELD_W'($signed(v));
  endfunction

  // last entry in use, with the count held to 1..TABLE_DEPTH
  function automatic logic [ADDR_W-1:0] last_index(input logic [COUNT_W-1:0] cnt);
    int n;
    n = int'(cnt);
    if (n == 0) begin
      n = 1;
    end
    if (n > TABLE_DEPTH) begin
      n = TABLE_DEPTH;
    end
    return ADDR_W'(n - 1);
  endfunction

  function automatic acc_t sext(input value_t v);
    return ACC_W'($signed(v));
  endfunction

endpackage

@@ design/tli_ram.sv @@
// ----------------------------------------------------------------------------
// tli_ram
// Simple dual-port RAM, one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/table_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear interpolation over a table of (x, y) breakpoints held in
// RAM. A query clamps to the first or last entry or searches linearly for
// the bracketing segment, then multiplies and divides bit-serially on one
// shared adder.
// Load items may follow back to back. A query clamped to the first entry
// passes the first-entry check only; one clamped to the last entry passes
// the last-entry check too; an interior query then searches, reading one
// table entry from RAM per step, and multiplies, divides and fixes the sign.
// The next input is taken once the result is registered.
// One item is worked at a time; the output register frees the next input.
// Reset clears the sequencer, output valid and the two registers
// (descending 1, count 1); table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module table_linear_interpolator
  import tli_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               func,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [FIELD_W-1:0] x_value,
  input  logic [FIELD_W-1:0] y_value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [FIELD_W-1:0] y_result,
  output logic [1:0]         clamp_code,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [COUNT_W-1:0] cfg_data
);

  state_t state, state_next;

  logic               descending_order;
  logic [COUNT_W-1:0] entry_count;

  logic               desc;
  value_t             qx;
  logic [ADDR_W-1:0]  last;
  logic [ADDR_W-1:0]  idx;
  value_t             prev_x, prev_y, cur_x, cur_y;
  value_t             mult, wb, dvsr, rem;
  acc_t               acc, mcand;
  logic [STEP_W-1:0]  cnt;
  logic               neg;
  value_t             res_y;
  logic [1:0]         res_code;

  logic               item_xfer;
  logic               wr_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  value_t             rd_x, rd_y;

  acc_t               alu_a, alu_b, alu_sum;
  logic               alu_sub;
  logic               alu_neg, alu_zero, alu_gt;
  logic               out_free, step_end;
  logic [VALUE_WIDTH:0] trial;

  assign item_stall = (state != S_IDLE);
  assign item_xfer  = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;
  assign step_end   = (cnt == STEP_W'(VALUE_WIDTH - 1));

  assign wr_en = item_xfer && (func == FUNC_LOAD) && (int'(entry_index) < TABLE_DEPTH);

  tli_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(ADDR_W'(entry_index)),
    .wr_data({to_value(x_value), to_value(y_value)}),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_x = rd_data[ENTRY_W-1:VALUE_WIDTH];
  assign rd_y = rd_data[VALUE_WIDTH-1:0];

  // shared adder
  assign alu_sum  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_neg  = alu_sum[ACC_W-1];
  assign alu_zero = (alu_sum == '0);
  assign alu_gt   = !alu_neg && !alu_zero;

  assign trial = {rem, mult[VALUE_WIDTH-1]};

  always_comb begin
    state_next = state;
    alu_a      = sext(qx);
    alu_b      = sext(rd_x);
    alu_sub    = 1'b1;
    rd_addr    = idx;
    case (state)
      S_IDLE: begin
        rd_addr = '0;
        if (item_xfer && func == FUNC_QUERY) begin
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        rd_addr = last;
        if (desc ? !alu_neg : !alu_gt) begin
          state_next = S_PUT;
        end else begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        rd_addr = ADDR_W'(1);
        if (desc ? !alu_gt : !alu_neg) begin
          state_next = S_PUT;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        rd_addr = idx + ADDR_W'(1);
        if (!((desc ? alu_neg : alu_gt) && idx < last)) begin
          state_next = S_WA;
        end
      end
      S_WA: begin
        alu_a      = desc ? sext(qx) : sext(cur_x);
        alu_b      = desc ? sext(cur_x) : sext(qx);
        state_next = S_WB;
      end
      S_WB: begin
        alu_a      = desc ? sext(prev_x) : sext(qx);
        alu_b      = desc ? sext(qx) : sext(prev_x);
        state_next = S_DIST;
      end
      S_DIST: begin
        alu_a      = desc ? sext(prev_x) : sext(cur_x);
        alu_b      = desc ? sext(cur_x) : sext(prev_x);
        state_next = S_MUL_A;
      end
      S_MUL_A, S_MUL_B: begin
        alu_a   = acc;
        alu_b   = mult[0] ? mcand : '0;
        alu_sub = 1'b0;
        if (step_end) begin
          state_next = (state == S_MUL_A) ? S_MUL_B : S_ABS;
        end
      end
      S_ABS: begin
        alu_a      = '0;
        alu_b      = acc;
        state_next = S_DIV;
      end
      S_DIV: begin
        alu_a = ACC_W'(trial);
        alu_b = ACC_W'(dvsr);
        if (step_end) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        alu_a      = '0;
        alu_b      = ACC_W'(mult);
        alu_sub    = neg;
        state_next = S_PUT;
      end
      S_PUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      descending_order <= 1'b1;
      entry_count      <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DESCENDING:  descending_order <= cfg_data[0];
        REG_ENTRY_COUNT: entry_count      <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        qx   <= to_value(x_value);
        desc <= descending_order;
        last <= last_index(entry_count);
      end
      S_FIRST: begin
        prev_x   <= rd_x;
        prev_y   <= rd_y;
        res_y    <= rd_y;
        res_code <= CLAMP_FIRST;
      end
      S_LAST: begin
        res_y    <= rd_y;
        res_code <= CLAMP_LAST;
        idx      <= ADDR_W'(1);
      end
      S_SEARCH: begin
        if ((desc ? alu_neg : alu_gt) && idx < last) begin
          prev_x <= rd_x;
          prev_y <= rd_y;
          idx    <= idx + ADDR_W'(1);
        end else begin
          cur_x <= rd_x;
          cur_y <= rd_y;
        end
      end
      S_WA: begin
        mult <= alu_sum[VALUE_WIDTH-1:0];
      end
      S_WB: begin
        wb <= alu_sum[VALUE_WIDTH-1:0];
      end
      S_DIST: begin
        dvsr  <= alu_sum[VALUE_WIDTH-1:0];
        acc   <= '0;
        mcand <= sext(prev_y);
        cnt   <= '0;
      end
      S_MUL_A, S_MUL_B: begin
        acc <= alu_sum;
        if (step_end && state == S_MUL_A) begin
          mult  <= wb;
          mcand <= sext(cur_y);
          cnt   <= '0;
        end else begin
          mult  <= {1'b0, mult[VALUE_WIDTH-1:1]};
          mcand <= {mcand[ACC_W-2:0], 1'b0};
          cnt   <= cnt + STEP_W'(1);
        end
      end
      S_ABS: begin
        neg <= acc[ACC_W-1];
        if (acc[ACC_W-1]) begin
          rem  <= alu_sum[2*VALUE_WIDTH-1:VALUE_WIDTH];
          mult <= alu_sum[VALUE_WIDTH-1:0];
        end else begin
          rem  <= acc[2*VALUE_WIDTH-1:VALUE_WIDTH];
          mult <= acc[VALUE_WIDTH-1:0];
        end
        cnt <= '0;
      end
      S_DIV: begin
        rem  <= alu_neg ? trial[VALUE_WIDTH-1:0] : alu_sum[VALUE_WIDTH-1:0];
        mult <= {mult[VALUE_WIDTH-2:0], !alu_neg};
        cnt  <= cnt + STEP_W'(1);
      end
      S_FIX: begin
        res_y    <= alu_sum[VALUE_WIDTH-1:0];
        res_code <= CLAMP_NONE;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_PUT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUT && out_free) begin
      y_result   <= to_field(res_y);
      clamp_code <= res_code;
    end
  end

endmodule
